@@ design/rnc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnc_pkg
// Shared types, codes and numeral tables of the Roman numeral calculator.
// ----------------------------------------------------------------------------
package rnc_pkg;

    // Widths of the item fields.
    localparam int OP_W      = 3;
    localparam int VAL_W     = 12;
    localparam int WIDE_W    = 24;
    localparam int SYM_W     = 8;
    localparam int STATUS_W  = 3;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 8;

    // Numeral table and divider sizes.
    localparam int NUM_STEPS = 13;
    localparam int STEP_W    = 4;
    localparam int DIV_STEPS = 12;
    localparam int CNT_W     = 4;

    // Operation selector codes.
    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_DIV = 3'd2,
        OP_MUL = 3'd3,
        OP_MOD = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 3'd0,
        ST_ZERO = 3'd1,
        ST_NEG  = 3'd2,
        ST_BIG  = 3'd3,
        ST_DIVZ = 3'd4
    } status_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_CHECK,
        BK_EMIT,
        BK_ERROR
    } back_state_t;

    // One classified transaction on its way from the front to the back.
    typedef struct packed {
        logic               err;
        status_t            code;
        logic               is_div;
        logic               is_mod;
        logic [WIDE_W-1:0]  value;
        logic [VAL_W-1:0]   divisor;
    } q_entry_t;

    // ASCII letters used by the numerals.
    localparam logic [SYM_W-1:0] CH_NONE = 8'h00;
    localparam logic [SYM_W-1:0] CH_I    = 8'h49;
    localparam logic [SYM_W-1:0] CH_V    = 8'h56;
    localparam logic [SYM_W-1:0] CH_X    = 8'h58;
    localparam logic [SYM_W-1:0] CH_L    = 8'h4C;
    localparam logic [SYM_W-1:0] CH_C    = 8'h43;
    localparam logic [SYM_W-1:0] CH_D    = 8'h44;
    localparam logic [SYM_W-1:0] CH_M    = 8'h4D;

    // Value of each greedy step, largest first.
    function automatic logic [VAL_W-1:0] step_value(input logic [STEP_W-1:0] idx);
        logic [VAL_W-1:0] v;
        unique case (idx)
            4'd0:    v = 12'd1000;
            4'd1:    v = 12'd900;
            4'd2:    v = 12'd500;
            4'd3:    v = 12'd400;
            4'd4:    v = 12'd100;
            4'd5:    v = 12'd90;
            4'd6:    v = 12'd50;
            4'd7:    v = 12'd40;
            4'd8:    v = 12'd10;
            4'd9:    v = 12'd9;
            4'd10:   v = 12'd5;
            4'd11:   v = 12'd4;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    // First letter of each step.
    function automatic logic [SYM_W-1:0] step_first(input logic [STEP_W-1:0] idx);
        logic [SYM_W-1:0] c;
        unique case (idx)
            4'd0:    c = CH_M;
            4'd1:    c = CH_C;
            4'd2:    c = CH_D;
            4'd3:    c = CH_C;
            4'd4:    c = CH_C;
            4'd5:    c = CH_X;
            4'd6:    c = CH_L;
            4'd7:    c = CH_X;
            4'd8:    c = CH_X;
            4'd9:    c = CH_I;
            4'd10:   c = CH_V;
            4'd11:   c = CH_I;
            default: c = CH_I;
        endcase
        return c;
    endfunction

    // Second letter of the subtractive steps, none for the others.
    function automatic logic [SYM_W-1:0] step_second(input logic [STEP_W-1:0] idx);
        logic [SYM_W-1:0] c;
        unique case (idx)
            4'd1:    c = CH_M;
            4'd3:    c = CH_D;
            4'd5:    c = CH_C;
            4'd7:    c = CH_L;
            4'd9:    c = CH_X;
            4'd11:   c = CH_V;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

@@ design/rnc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnc_front
// Classifies each incoming transaction: computes sum, difference or product,
// flags negative and divide-by-zero cases and prepares divide requests.
// ----------------------------------------------------------------------------
module rnc_front (
    input  logic [rnc_pkg::OP_W-1:0]  op,
    input  logic [rnc_pkg::VAL_W-1:0] left_value,
    input  logic [rnc_pkg::VAL_W-1:0] right_value,
    output rnc_pkg::q_entry_t         entry
);

    logic [rnc_pkg::WIDE_W-1:0] product;
    logic [rnc_pkg::WIDE_W-1:0] sum;
    logic [rnc_pkg::WIDE_W-1:0] diff;

    // Combinational arithmetic.
    assign product = rnc_pkg::WIDE_W'(left_value) * rnc_pkg::WIDE_W'(right_value);
    assign sum     = rnc_pkg::WIDE_W'(left_value) + rnc_pkg::WIDE_W'(right_value);
    assign diff    = rnc_pkg::WIDE_W'(left_value - right_value);

    // Classification of the operation.
    always_comb begin
        entry         = '0;
        entry.code    = rnc_pkg::ST_OK;
        entry.divisor = right_value;
        unique case (rnc_pkg::op_t'(op))
            rnc_pkg::OP_ADD: begin
                entry.value = sum;
            end
            rnc_pkg::OP_SUB: begin
                if (left_value < right_value) begin
                    entry.err  = 1'b1;
                    entry.code = rnc_pkg::ST_NEG;
                end
                entry.value = diff;
            end
            rnc_pkg::OP_MUL: begin
                entry.value = product;
            end
            rnc_pkg::OP_DIV, rnc_pkg::OP_MOD: begin
                if (right_value == '0) begin
                    entry.err  = 1'b1;
                    entry.code = rnc_pkg::ST_DIVZ;
                end
                entry.is_div = 1'b1;
                entry.is_mod = (rnc_pkg::op_t'(op) == rnc_pkg::OP_MOD);
                entry.value  = rnc_pkg::WIDE_W'(left_value);
            end
            default: begin
                // Unknown selectors yield a zero result.
                entry.value = '0;
            end
        endcase
    end

endmodule

@@ design/rnc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnc_queue
// Small first-in first-out buffer of classified transactions between the
// front and the back.
// ----------------------------------------------------------------------------
module rnc_queue #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rnc_pkg::q_entry_t push_entry,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output rnc_pkg::q_entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rnc_pkg::q_entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/rnc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnc_back
// Executes queued transactions: runs the bit-serial divider, range checks the
// result and spells it out one Roman letter per output transaction.
// ----------------------------------------------------------------------------
module rnc_back #(
    parameter int MAX_VALUE = 3999
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  rnc_pkg::q_entry_t             q_entry,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rnc_pkg::SYM_W-1:0]     m_symbol,
    output logic [rnc_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_last
);

    rnc_pkg::back_state_t state_reg, state_next;

    logic [rnc_pkg::WIDE_W-1:0]   val_reg, val_next;
    logic [rnc_pkg::VAL_W-1:0]    rem_reg, rem_next;
    logic [rnc_pkg::VAL_W-1:0]    quo_reg, quo_next;
    logic [rnc_pkg::VAL_W-1:0]    div_reg, div_next;
    logic [rnc_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         is_mod_reg, is_mod_next;
    logic                         pending_reg, pending_next;
    rnc_pkg::status_t             code_reg, code_next;

    logic                         out_valid_reg, out_valid_next;
    logic [rnc_pkg::SYM_W-1:0]    sym_reg, sym_next;
    rnc_pkg::status_t             status_reg, status_next;
    logic                         last_reg, last_next;

    logic                         slot_free;
    logic [rnc_pkg::VAL_W:0]      shifted;
    logic                         fits;
    logic [rnc_pkg::VAL_W-1:0]    digit_val;
    logic [rnc_pkg::STEP_W-1:0]   pick;
    logic [rnc_pkg::VAL_W-1:0]    pick_val;
    logic [rnc_pkg::SYM_W-1:0]    pick_second;
    logic [rnc_pkg::VAL_W-1:0]    remain;

    assign m_tvalid  = out_valid_reg;
    assign m_symbol  = sym_reg;
    assign m_status  = status_reg;
    assign m_last    = last_reg;
    assign slot_free = !out_valid_reg || m_tready;

    // One restoring division step.
    assign shifted = {rem_reg, quo_reg[rnc_pkg::VAL_W-1]};
    assign fits    = (shifted >= {1'b0, div_reg});

    // Largest table step that still fits in the remaining value.
    assign digit_val = val_reg[rnc_pkg::VAL_W-1:0];
    always_comb begin
        pick = rnc_pkg::STEP_W'(rnc_pkg::NUM_STEPS - 1);
        for (int i = rnc_pkg::NUM_STEPS - 1; i >= 0; i--) begin
            if (digit_val >= rnc_pkg::step_value(rnc_pkg::STEP_W'(i))) begin
                pick = rnc_pkg::STEP_W'(i);
            end
        end
    end
    assign pick_val    = rnc_pkg::step_value(pick);
    assign pick_second = rnc_pkg::step_second(pick);
    assign remain      = digit_val - pick_val;

    // Sequencer next state and datapath.
    always_comb begin
        state_next     = state_reg;
        val_next       = val_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        cnt_next       = cnt_reg;
        is_mod_next    = is_mod_reg;
        pending_next   = pending_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !m_tready;
        sym_next       = sym_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            rnc_pkg::BK_IDLE: begin
                if (q_valid) begin
                    q_pop        = 1'b1;
                    val_next     = q_entry.value;
                    quo_next     = q_entry.value[rnc_pkg::VAL_W-1:0];
                    rem_next     = '0;
                    div_next     = q_entry.divisor;
                    cnt_next     = '0;
                    is_mod_next  = q_entry.is_mod;
                    pending_next = 1'b0;
                    code_next    = q_entry.code;
                    if (q_entry.err) begin
                        state_next = rnc_pkg::BK_ERROR;
                    end else if (q_entry.is_div) begin
                        state_next = rnc_pkg::BK_DIVIDE;
                    end else begin
                        state_next = rnc_pkg::BK_CHECK;
                    end
                end
            end

            rnc_pkg::BK_DIVIDE: begin
                rem_next = fits ? rnc_pkg::VAL_W'(shifted - {1'b0, div_reg})
                                : shifted[rnc_pkg::VAL_W-1:0];
                quo_next = {quo_reg[rnc_pkg::VAL_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == rnc_pkg::CNT_W'(rnc_pkg::DIV_STEPS - 1)) begin
                    val_next   = is_mod_reg ? rnc_pkg::WIDE_W'(rem_next)
                                            : rnc_pkg::WIDE_W'(quo_next);
                    state_next = rnc_pkg::BK_CHECK;
                end
            end

            rnc_pkg::BK_CHECK: begin
                if (val_reg == '0) begin
                    code_next  = rnc_pkg::ST_ZERO;
                    state_next = rnc_pkg::BK_ERROR;
                end else if (val_reg > rnc_pkg::WIDE_W'(MAX_VALUE)) begin
                    code_next  = rnc_pkg::ST_BIG;
                    state_next = rnc_pkg::BK_ERROR;
                end else begin
                    state_next = rnc_pkg::BK_EMIT;
                end
            end

            rnc_pkg::BK_EMIT: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    status_next    = rnc_pkg::ST_OK;
                    if ((pick_second != rnc_pkg::CH_NONE) && !pending_reg) begin
                        // First letter of a subtractive pair.
                        sym_next     = rnc_pkg::step_first(pick);
                        pending_next = 1'b1;
                        last_next    = 1'b0;
                    end else begin
                        sym_next     = pending_reg ? pick_second : rnc_pkg::step_first(pick);
                        pending_next = 1'b0;
                        val_next     = rnc_pkg::WIDE_W'(remain);
                        last_next    = (remain == '0);
                        if (remain == '0) begin
                            state_next = rnc_pkg::BK_IDLE;
                        end
                    end
                end
            end

            rnc_pkg::BK_ERROR: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    sym_next       = rnc_pkg::CH_NONE;
                    status_next    = code_reg;
                    last_next      = 1'b1;
                    state_next     = rnc_pkg::BK_IDLE;
                end
            end

            default: begin
                state_next = rnc_pkg::BK_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rnc_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pending_reg   <= pending_next;
        end
    end

    // Datapath and output payload registers.
    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        div_reg    <= div_next;
        cnt_reg    <= cnt_next;
        is_mod_reg <= is_mod_next;
        code_reg   <= code_next;
        sym_reg    <= sym_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

endmodule

@@ design/roman_numeral_calculator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_calculator
// Computes add, subtract, divide, multiply or modulo of two operands and
// streams the result out as a subtractive Roman numeral, one letter per item.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on the s_ channel carries an operation code and two
// 12-bit operands. The m_ channel returns one transaction per ASCII letter of
// the numeral, with m_tlast on the final letter and status 0 in m_tuser. A
// zero, negative or too large result, or a divide by zero, gives instead one
// transaction with symbol 0, the error status and m_tlast set.
// The front classifies and computes add, subtract and multiply in the cycle a
// transaction is accepted and places it in a queue. The back takes one entry
// at a time: the bit-serial divider for divide and modulo, then a range
// check, then one letter per cycle while m_tready allows (up to 15
// letters). An error flagged by the front or by the range check gives
// the single error transaction instead. The queue keeps accepting while
// the back works. When m_tready is low the current letter holds and the
// back waits.
// Reset empties the queue and drops any result in progress.
// ----------------------------------------------------------------------------
module roman_numeral_calculator #(
    parameter int MAX_VALUE   = 3999,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: op [2:0], left_value [14:3], right_value [26:15], zeros above
    input  logic [rnc_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // m_tdata: symbol [7:0]
    output logic [rnc_pkg::M_DATA_W-1:0]     m_tdata,
    // m_tuser: status [2:0]
    output logic [rnc_pkg::STATUS_W-1:0]     m_tuser,
    output logic                             m_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready
);

    rnc_pkg::q_entry_t front_entry;
    rnc_pkg::q_entry_t back_entry;
    logic              q_not_full;
    logic              q_not_empty;
    logic              q_pop;

    assign s_tready = q_not_full;

    // Front: classification and combinational arithmetic.
    rnc_front u_front (
        .op          (s_tdata[2:0]),
        .left_value  (s_tdata[14:3]),
        .right_value (s_tdata[26:15]),
        .entry       (front_entry)
    );

    // Queue between front and back.
    rnc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid),
        .push_entry (front_entry),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .pop_entry  (back_entry)
    );

    // Back: divider, range check and numeral output.
    rnc_back #(
        .MAX_VALUE (MAX_VALUE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_entry  (back_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_symbol (m_tdata),
        .m_status (m_tuser),
        .m_last   (m_tlast)
    );

endmodule
